// ===== hw/rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps

package u8u16_pkg;

	// Error codes carried on error_code
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
	localparam logic [2:0] ERR_TRUNCATED = 3'd2;
	localparam logic [2:0] ERR_BAD_CONT  = 3'd3;
	localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

	localparam logic [30:0] CP_MAX     = 31'h0010FFFF;
	localparam logic [30:0] CP_BMP_MAX = 31'h0000FFFF;
	localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
	localparam logic [15:0] HI_SURR    = 16'hD800;
	localparam logic [15:0] LO_SURR    = 16'hDC00;

	// One result item
	typedef struct packed {
		logic [15:0] code_unit;
		logic [2:0]  error_code;
		logic        run_last;
		logic        text_last;
	} result_t;

	// Results caused by one byte: none, one, or a surrogate pair
	typedef struct packed {
		logic    res0_valid;
		logic    res1_valid;
		result_t res0;
		result_t res1;
	} dec_t;

	// Lead byte decode: continuation count (1..5), ok flag in the top bit
	function automatic logic [3:0] lead_info(input logic [7:0] b);
		logic [3:0] r;
		r = 4'b0000;
		case (b) inside
			8'b110?????: r = {1'b1, 3'd1};
			8'b1110????: r = {1'b1, 3'd2};
			8'b11110???: r = {1'b1, 3'd3};
			8'b111110??: r = {1'b1, 3'd4};
			8'b1111110?: r = {1'b1, 3'd5};
			default:     r = 4'b0000;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/u8u16_decode.sv =====
`timescale 1ns / 1ps

module u8u16_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_s1,
	input  logic                last_s1,
	input  logic                adv,
	output u8u16_pkg::dec_t     dec
);

	logic [30:0] acc_q;
	logic [2:0]  pend_q;
	logic        drop_q;

	logic [30:0] acc_d;
	logic [2:0]  pend_d;
	logic        drop_d;
	logic [2:0]  err;
	logic [3:0]  lead;
	logic [30:0] cp;
	logic [20:0] v;

	always_comb begin
		dec    = '0;
		acc_d  = acc_q;
		pend_d = pend_q;
		drop_d = drop_q;
		err    = u8u16_pkg::ERR_NONE;
		lead   = u8u16_pkg::lead_info(byte_s1);
		cp     = {acc_q[24:0], byte_s1[5:0]};
		v      = cp[20:0] - u8u16_pkg::CP_SUPP_BASE;

		if (drop_q) begin
			// discard until end of text
		end else if (pend_q == 3'd0) begin
			if (!byte_s1[7]) begin
				dec.res0_valid = 1'b1;
				dec.res0 = '{code_unit: {8'h00, byte_s1}, error_code: u8u16_pkg::ERR_NONE,
					run_last: 1'b1, text_last: last_s1};
			end else if (!lead[3]) begin
				err = u8u16_pkg::ERR_BAD_LEAD;
			end else if (last_s1) begin
				err = u8u16_pkg::ERR_TRUNCATED;
			end else begin
				acc_d  = {23'd0, byte_s1 & (8'h3F >> lead[2:0])};
				pend_d = lead[2:0];
			end
		end else if (last_s1 && pend_q >= 3'd2) begin
			err = u8u16_pkg::ERR_TRUNCATED;
		end else if (byte_s1[7:6] == 2'b10) begin
			acc_d  = cp;
			pend_d = pend_q - 3'd1;
			if (pend_q == 3'd1) begin
				// sequence complete: emit one unit or a surrogate pair
				acc_d = '0;
				if (cp > u8u16_pkg::CP_MAX) begin
					err = u8u16_pkg::ERR_TOO_LARGE;
				end else if (cp > u8u16_pkg::CP_BMP_MAX) begin
					dec.res0_valid = 1'b1;
					dec.res1_valid = 1'b1;
					dec.res0 = '{code_unit: u8u16_pkg::HI_SURR | {6'd0, v[19:10]},
						error_code: u8u16_pkg::ERR_NONE, run_last: 1'b0, text_last: 1'b0};
					dec.res1 = '{code_unit: u8u16_pkg::LO_SURR | {6'd0, v[9:0]},
						error_code: u8u16_pkg::ERR_NONE, run_last: 1'b1, text_last: last_s1};
				end else begin
					dec.res0_valid = 1'b1;
					dec.res0 = '{code_unit: cp[15:0], error_code: u8u16_pkg::ERR_NONE,
						run_last: 1'b1, text_last: last_s1};
				end
			end
		end else begin
			err = u8u16_pkg::ERR_BAD_CONT;
		end

		// error: single report, then drop the rest of the text
		if (err != u8u16_pkg::ERR_NONE) begin
			dec.res0_valid = 1'b1;
			dec.res1_valid = 1'b0;
			dec.res0 = '{code_unit: 16'h0000, error_code: err, run_last: 1'b1,
				text_last: last_s1};
			acc_d  = '0;
			pend_d = 3'd0;
			drop_d = 1'b1;
		end

		if (last_s1) begin
			acc_d  = '0;
			pend_d = 3'd0;
			drop_d = 1'b0;
		end
	end

	// Decoder state, updated when the byte in s1 moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= 3'd0;
			drop_q <= 1'b0;
		end else if (adv) begin
			acc_q  <= acc_d;
			pend_q <= pend_d;
			drop_q <= drop_d;
		end
	end

endmodule

// ===== hw/rtl/u8u16_out.sv =====
`timescale 1ns / 1ps

module u8u16_out (
	input  logic                clk,
	input  logic                arst_n,
	input  u8u16_pkg::dec_t     dec,
	input  logic                push,
	input  logic                out_stall,
	output logic                out_valid,
	output u8u16_pkg::result_t  res,
	output logic                out_free,
	output logic                pend_busy
);

	logic                 out_valid_q;
	u8u16_pkg::result_t   out_q;
	logic                 pend_valid_q;
	u8u16_pkg::result_t   pend_q;
	logic                 take;

	assign take      = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign pend_busy = pend_valid_q;
	assign out_valid = out_valid_q;
	assign res       = out_q;

	// Valid bits: output register plus a holding slot for the second unit of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end else if (push && dec.res0_valid) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= dec.res1_valid;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			if (out_free) begin
				out_q <= pend_q;
			end
		end else if (push && dec.res0_valid) begin
			out_q  <= dec.res0;
			pend_q <= dec.res1;
		end
	end

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder_top.sv =====
`timescale 1ns / 1ps
// Path: input register, combinational decode, output register, output port.
// Throughput: one byte per cycle while the output accepts; a byte completing a
// surrogate pair stalls input while the single output register drains unit two.
// Reset (arst_n low, asynchronous): pipeline empty, decoder state cleared,
// no text in progress.
module utf8_to_utf16_transcoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic [2:0]  error_code,
	output logic        run_last,
	output logic        text_last
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                adv;
	logic                out_free;
	logic                pend_busy;
	u8u16_pkg::dec_t     dec;
	u8u16_pkg::result_t  res;

	// s1 byte leaves when the output side can take all of its results
	assign adv      = valid_s1 && !pend_busy && (out_free || !dec.res0_valid);
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_value;
			last_s1 <= last_of_text;
		end
	end

	u8u16_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.adv     (adv),
		.dec     (dec)
	);

	u8u16_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (dec),
		.push      (adv),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res),
		.out_free  (out_free),
		.pend_busy (pend_busy)
	);

	assign code_unit  = res.code_unit;
	assign error_code = res.error_code;
	assign run_last   = res.run_last;
	assign text_last  = res.text_last;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Tracks expected UTF-16 units: mirrors the decoder state and queues the units
// each accepted UTF-8 byte should produce, then matches the DUT output against them.
class utf16_unit_tracker;
	logic [30:0] cp_acc;
	logic [2:0]  cont_left;
	bit          dropping;
	u8u16_pkg::result_t units_due[$];
	int fails;

	function void add_unit(logic [15:0] u, logic [2:0] e, logic rl, logic tl);
		u8u16_pkg::result_t r;
		r.code_unit  = u;
		r.error_code = e;
		r.run_last   = rl;
		r.text_last  = tl;
		units_due.push_back(r);
	endfunction

	// Queue the unit(s) for a finished code point; returns the error it raises
	function logic [2:0] emit_point(logic [30:0] cp, logic fin);
		logic [20:0] offs;
		if (cp > u8u16_pkg::CP_MAX)
			return u8u16_pkg::ERR_TOO_LARGE;
		if (cp > u8u16_pkg::CP_BMP_MAX) begin
			offs = cp[20:0] - u8u16_pkg::CP_SUPP_BASE;
			add_unit(u8u16_pkg::HI_SURR | {6'd0, offs[19:10]}, u8u16_pkg::ERR_NONE,
				1'b0, 1'b0);
			add_unit(u8u16_pkg::LO_SURR | {6'd0, offs[9:0]}, u8u16_pkg::ERR_NONE,
				1'b1, fin);
		end else begin
			add_unit(cp[15:0], u8u16_pkg::ERR_NONE, 1'b1, fin);
		end
		return u8u16_pkg::ERR_NONE;
	endfunction

	// Decode one accepted input byte
	function void take_byte(logic [7:0] b, logic fin);
		logic [2:0] err;
		logic [7:0] t;
		int ones;
		err = u8u16_pkg::ERR_NONE;
		if (dropping) begin
			if (fin)
				dropping = 1'b0;
			return;
		end
		if (cont_left == 3'd0) begin
			if (!b[7]) begin
				err = emit_point({23'd0, b}, fin);
			end else begin
				ones = 0;
				t = b;
				while (ones < 8 && t[7]) begin
					ones++;
					t = t << 1;
				end
				if (ones < 2 || ones > 6)
					err = u8u16_pkg::ERR_BAD_LEAD;
				else if (fin)
					err = u8u16_pkg::ERR_TRUNCATED;
				else begin
					cp_acc = 31'(b & (8'h7F >> ones));
					cont_left = 3'(ones - 1);
				end
			end
		end else if (fin && cont_left >= 3'd2) begin
			err = u8u16_pkg::ERR_TRUNCATED;
		end else if (b[7:6] == 2'b10) begin
			cp_acc = {cp_acc[24:0], b[5:0]};
			cont_left--;
			if (cont_left == 3'd0) begin
				err = emit_point(cp_acc, fin);
				cp_acc = '0;
			end
		end else begin
			err = u8u16_pkg::ERR_BAD_CONT;
		end

		// First error of a text: one error unit, then drop until end of text
		if (err != u8u16_pkg::ERR_NONE) begin
			add_unit(16'd0, err, 1'b1, fin);
			dropping = 1'b1;
		end
		if (fin || err != u8u16_pkg::ERR_NONE) begin
			cp_acc = '0;
			cont_left = '0;
		end
		if (fin)
			dropping = 1'b0;
	endfunction

	// Compare one output transfer with the oldest expected unit
	function void match_unit(logic [15:0] u, logic [2:0] e, logic rl, logic tl);
		u8u16_pkg::result_t got, want;
		got.code_unit  = u;
		got.error_code = e;
		got.run_last   = rl;
		got.text_last  = tl;
		if (units_due.size() == 0) begin
			fails++;
			if (fails <= 40)
				$display("%0t: unexpected unit %h err %0d run_last %0b text_last %0b",
					$time, u, e, rl, tl);
			return;
		end
		want = units_due.pop_front();
		if (got !== want) begin
			fails++;
			if (fails <= 40)
				$display({"%0t: mismatch, expected unit %h err %0d rl %0b tl %0b,",
					" actual unit %h err %0d rl %0b tl %0b"},
					$time, want.code_unit, want.error_code, want.run_last,
					want.text_last, u, e, rl, tl);
		end
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BYTES = 250;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_value;
	logic        last_of_text;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] code_unit;
	logic [2:0]  error_code;
	logic        run_last;
	logic        text_last;

	utf16_unit_tracker tracker = new;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_request;
	int bytes_sent;
	int cycle_count;
	logic [7:0] text_bytes[$];

	utf8_to_utf16_transcoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_value(byte_value),
		.last_of_text(last_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_unit(code_unit),
		.error_code(error_code),
		.run_last(run_last),
		.text_last(text_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Output side: check at the rising edge, pick stall at the falling edge
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				tracker.match_unit(code_unit, error_code, run_last, text_last);
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
			end
		end
	end

	// One byte transfer; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		byte_value   <= b;
		last_of_text <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_byte(b, fin);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_bytes[i])
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
	endtask

	// Append one encoded code point of random length (overlong and oversized included)
	function void put_random_point();
		int unsigned w, len;
		logic [30:0] cp;
		logic [7:0] lead;
		w = $urandom_range(0, 99);
		len = (w < 30) ? 1 : (w < 50) ? 2 : (w < 70) ? 3 : (w < 90) ? 4 : (w < 95) ? 5 : 6;
		case (len)
			1: cp = 31'($urandom_range(0, 'h7F));
			2: cp = 31'($urandom_range(0, 'h7FF));
			3: cp = 31'($urandom_range(0, 'hFFFF));
			4: cp = ($urandom_range(0, 9) < 8) ? 31'($urandom_range('h10000, 'h10FFFF))
				: 31'($urandom_range(0, 'h1FFFFF));
			5: cp = ($urandom_range(0, 9) < 3) ? 31'($urandom_range(0, 'h10FFFF))
				: 31'($urandom_range(0, 'h3FFFFFF));
			default: cp = ($urandom_range(0, 9) < 3) ? 31'($urandom_range(0, 'h10FFFF))
				: 31'($urandom);
		endcase
		if (len == 1) begin
			text_bytes.push_back({1'b0, cp[6:0]});
		end else begin
			lead = 8'hFF << (8 - len);
			lead = lead | (8'(cp >> (6 * (len - 1))) & (8'h7F >> len));
			text_bytes.push_back(lead);
			for (int k = len - 2; k >= 0; k--)
				text_bytes.push_back({2'b10, 6'(cp >> (6 * k))});
		end
	endfunction

	// Mostly well-formed texts; some corrupted, truncated or pure noise
	task automatic send_random_text();
		int unsigned pick, cut;
		text_bytes.delete();
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			repeat ($urandom_range(1, 4))
				text_bytes.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 6))
				put_random_point();
			if (pick < 13) begin
				text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
			end else if (pick < 20 && text_bytes.size() > 1) begin
				cut = $urandom_range(1, text_bytes.size() - 1);
				repeat (cut)
					void'(text_bytes.pop_back());
			end
		end
		send_text();
	endtask

	// Main sequence
	initial begin
		int goal;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		byte_value     = 8'd0;
		last_of_text   = 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_request   = 0;
		bytes_sent     = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed texts
		text_bytes = '{8'h00, 8'h7F};             send_text();  // ASCII extremes
		text_bytes = '{8'hC3, 8'hA9};             send_text();
		text_bytes = '{8'hE2, 8'h82, 8'hAC};      send_text();
		text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text(); // top code point, pair
		text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_text(); // above range
		text_bytes = '{8'h80, 8'h41, 8'hFF};      send_text();  // lone continuation, drop
		text_bytes = '{8'hFE};                    send_text();  // too many leading ones
		text_bytes = '{8'hE2};                    send_text();  // lead ends the text
		text_bytes = '{8'hF0, 8'h9F};             send_text();  // ends two short
		text_bytes = '{8'hE2, 8'h82, 8'h41};      send_text();  // bad continuation
		text_bytes = '{8'hED, 8'hA0, 8'h80};      send_text();  // surrogate passes

		// Random phases with different idle patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
					hold_request = 300;  // long output hold to back the block up
				end
				1: begin
					src_idle_pct = 63;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 63;
				end
				default: begin
					src_idle_pct = 8;
					sink_stall_pct = 8;
				end
			endcase
			goal = bytes_sent + PHASE_BYTES;
			while (bytes_sent < goal)
				send_random_text();
		end
		in_valid <= 1'b0;

		// Drain, then a short tail for stray units
		while (tracker.units_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.fails == 0 && tracker.units_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
